### design/mcs_pkg.sv
// Shared types, constants and a helper function of the motion command sequencer.
package mcs_pkg;

  // Sizing of the command queue and the servo lanes.
  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned ServoCount   = 6;
  localparam int unsigned PositionBits = 8;
  localparam int unsigned LaneW        = 8;
  localparam int unsigned PtrW         = $clog2(QueueDepth);
  localparam int unsigned CntW         = $clog2(QueueDepth + 1);

  // Depth of the decoupling queue between the front and the back.
  localparam int unsigned FrontDepth   = 2;
  localparam int unsigned FrontPtrW    = $clog2(FrontDepth);
  localparam int unsigned FrontCntW    = $clog2(FrontDepth + 1);

  localparam logic [31:0] IdNone       = 32'hFFFF_FFFF;
  localparam logic [15:0] TimeoutReset = 16'd2000;
  localparam logic [5:0]  AllServos    = 6'((7'(1) << ServoCount) - 7'(1));

  // Input opcodes.
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ENQUEUE = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_ESTOP   = 3'd3,
    OP_GO_HOME = 3'd4
  } mcs_op_e;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_ACK      = 3'd0,
    EV_TIMEOUT  = 3'd1,
    EV_FINISHED = 3'd2,
    EV_EMPTY    = 3'd3,
    EV_STARTED  = 3'd4,
    EV_ESTOP    = 3'd5,
    EV_HOME     = 3'd6
  } mcs_event_e;

  // Classified work item handed from the front to the back.
  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_ENQUEUE = 3'd1,
    KIND_CLEAR   = 3'd2,
    KIND_ESTOP   = 3'd3,
    KIND_HOME    = 3'd4
  } mcs_kind_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] cmd_id;
    logic [5:0]         target_mask;
    logic [47:0]        target_positions;
    logic [47:0]        target_speeds;
    logic [5:0]         reached_mask;
    logic               all_idle;
    logic [31:0]        now_ms;
  } mcs_in_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic signed [31:0] event_id;
    logic [5:0]         servo_mask;
    logic [47:0]        drive_positions;
    logic [47:0]        drive_speeds;
    logic               accepted;
    logic [4:0]         queue_count;
    logic               running;
    logic               last;
  } mcs_out_t;

  typedef struct packed {
    mcs_kind_e   kind;
    logic [31:0] cmd_id;
    logic [5:0]  target_mask;
    logic [47:0] positions;
    logic [47:0] speeds;
    logic [5:0]  reached_mask;
    logic        all_idle;
    logic [31:0] now_ms;
  } mcs_item_t;

  // One stored command.
  typedef struct packed {
    logic [31:0] id;
    logic [5:0]  mask;
    logic [47:0] positions;
    logic [47:0] speeds;
  } mcs_entry_t;

  // Lane mask with the low 'bits' bits set in every lane whose servo is selected.
  function automatic logic [47:0] lane_mask(input logic [5:0] mask, input int unsigned bits);
    logic [47:0]      lanes;
    logic [LaneW-1:0] ones;
    lanes = '0;
    ones  = LaneW'((16'(1) << bits) - 16'd1);
    for (int unsigned i = 0; i < ServoCount; i++) begin
      if (mask[i]) begin
        lanes[LaneW*i +: LaneW] = ones;
      end
    end
    return lanes;
  endfunction

endpackage

### design/mcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mcs_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/mcs_front.sv
// Front end: accepts input beats, classifies them and buffers them for the back end.
module mcs_front import mcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mcs_in_t   in_data_i,
  output logic      item_valid_o,
  input  logic      item_ready_i,
  output mcs_item_t item_o
);

  mcs_item_t            buf_q [FrontDepth];
  logic [FrontPtrW-1:0] wptr_q, wptr_d;
  logic [FrontPtrW-1:0] rptr_q, rptr_d;
  logic [FrontCntW-1:0] cnt_q, cnt_d;
  mcs_item_t            item_c;
  logic                 known_op;
  logic                 push;
  logic                 pop;
  logic [5:0]           tmask;

  assign tmask = in_data_i.target_mask & AllServos;

  // Classify the opcode; unused opcodes are accepted and dropped.
  // Targets of absent servos are dropped and the lanes that are not driven are cleared.
  always_comb begin
    known_op    = 1'b1;
    item_c.kind = KIND_TICK;
    case (in_data_i.op)
      OP_TICK:    item_c.kind = KIND_TICK;
      OP_ENQUEUE: item_c.kind = KIND_ENQUEUE;
      OP_CLEAR:   item_c.kind = KIND_CLEAR;
      OP_ESTOP:   item_c.kind = KIND_ESTOP;
      OP_GO_HOME: item_c.kind = KIND_HOME;
      default:    known_op = 1'b0;
    endcase
    item_c.cmd_id       = in_data_i.cmd_id;
    item_c.target_mask  = tmask;
    item_c.positions    = in_data_i.target_positions & lane_mask(tmask, PositionBits);
    item_c.speeds       = in_data_i.target_speeds & lane_mask(tmask, LaneW);
    item_c.reached_mask = in_data_i.reached_mask;
    item_c.all_idle     = in_data_i.all_idle;
    item_c.now_ms       = in_data_i.now_ms;
  end

  assign in_ready_o   = (cnt_q != FrontCntW'(FrontDepth));
  assign push         = in_valid_i && in_ready_o && known_op;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = buf_q[rptr_q];

  // Queue pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == FrontPtrW'(FrontDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == FrontPtrW'(FrontDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= item_c;
    end
  end

endmodule

### design/mcs_back.sv
// Back end: holds the command queue, runs commands and emits the result beats.
module mcs_back import mcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  mcs_item_t item_i,
  input  logic      cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mcs_out_t  out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_EMIT = 3'b100
  } mcs_state_e;

  // Pending result slots, emitted lowest index first.
  localparam int unsigned PendW = 8;
  localparam logic [2:0] PB_ACK     = 3'd0;
  localparam logic [2:0] PB_TIMEOUT = 3'd1;
  localparam logic [2:0] PB_FINISH  = 3'd2;
  localparam logic [2:0] PB_EMPTY   = 3'd3;
  localparam logic [2:0] PB_START   = 3'd4;
  localparam logic [2:0] PB_FLUSH   = 3'd5;
  localparam logic [2:0] PB_ESTOP   = 3'd6;
  localparam logic [2:0] PB_HOME    = 3'd7;

  mcs_state_e  state_q, state_d;
  mcs_item_t   item_q, item_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [15:0] timeout_q;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic        busy_q, busy_d;
  logic [31:0] running_id_q, running_id_d;
  logic [5:0]  active_mask_q, active_mask_d;
  logic [31:0] start_time_q, start_time_d;
  logic [31:0] ended_id_q, ended_id_d;
  logic [5:0]  ended_mask_q, ended_mask_d;
  logic        ack_ok_q, ack_ok_d;
  logic [47:0] start_pos_q, start_pos_d;
  logic [47:0] start_spd_q, start_spd_d;
  logic        out_valid_q, out_valid_d;
  mcs_out_t    out_q, out_d;

  logic        ram_we;
  mcs_entry_t  ram_wdata;
  logic [$bits(mcs_entry_t)-1:0] ram_rdata;
  mcs_entry_t  head;
  logic        done;
  logic        late;
  logic        ended;
  logic [31:0] elapsed;
  logic [2:0]  sel;
  logic [PendW-1:0] rest;
  logic [CntW-1:0]  end_count;
  mcs_out_t    res;

  // Command storage; the read port always follows the head of the queue.
  assign ram_wdata.id        = item_q.cmd_id;
  assign ram_wdata.mask      = item_q.target_mask;
  assign ram_wdata.positions = item_q.positions;
  assign ram_wdata.speeds    = item_q.speeds;
  assign head                = mcs_entry_t'(ram_rdata);

  mcs_ram #(
    .DATA_W ($bits(mcs_entry_t)),
    .DEPTH  (QueueDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i (ram_wdata),
    .raddr_i (rptr_q),
    .rdata_o (ram_rdata)
  );

  // Completion and timeout checks of the running command.
  assign done    = (active_mask_q != '0) ? ((item_q.reached_mask & active_mask_q) == active_mask_q)
                                         : item_q.all_idle;
  assign elapsed = item_q.now_ms - start_time_q;
  assign late    = elapsed > {16'd0, timeout_q};
  assign ended   = busy_q && (done || late);

  // Pick the next pending result.
  always_comb begin
    sel = '0;
    for (int i = PendW - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign rest      = pend_q & ~(PendW'(1) << sel);
  assign end_count = count_q + CntW'(pend_q[PB_START]);

  // Build the result beat for the selected slot.
  always_comb begin
    res = '0;
    res.event_id    = IdNone;
    res.queue_count = 5'(count_q);
    res.running     = busy_q;
    res.last        = (rest == '0);
    case (sel)
      PB_ACK: begin
        res.event_res = EV_ACK;
        res.accepted  = ack_ok_q;
      end
      PB_TIMEOUT: begin
        res.event_res   = EV_TIMEOUT;
        res.servo_mask  = ended_mask_q;
        res.queue_count = 5'(end_count);
        res.running     = 1'b0;
      end
      PB_FINISH: begin
        res.event_res   = EV_FINISHED;
        res.event_id    = ended_id_q;
        res.queue_count = 5'(end_count);
        res.running     = 1'b0;
      end
      PB_EMPTY: begin
        res.event_res   = EV_EMPTY;
        res.queue_count = 5'(end_count);
        res.running     = 1'b0;
      end
      PB_START: begin
        res.event_res       = EV_STARTED;
        res.event_id        = running_id_q;
        res.servo_mask      = active_mask_q;
        res.drive_positions = start_pos_q;
        res.drive_speeds    = start_spd_q;
      end
      PB_FLUSH: begin
        res.event_res  = EV_EMPTY;
        res.servo_mask = AllServos;
      end
      PB_ESTOP: begin
        res.event_res = EV_ESTOP;
      end
      PB_HOME: begin
        res.event_res = EV_HOME;
      end
      default: begin
        res.event_res = EV_ACK;
      end
    endcase
  end

  assign item_ready_o = (state_q == ST_IDLE);

  // Sequencer: take an item, evaluate it in one step, then drain its results.
  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    pend_d        = pend_q;
    rptr_d        = rptr_q;
    wptr_d        = wptr_q;
    count_d       = count_q;
    busy_d        = busy_q;
    running_id_d  = running_id_q;
    active_mask_d = active_mask_q;
    start_time_d  = start_time_q;
    ended_id_d    = ended_id_q;
    ended_mask_d  = ended_mask_q;
    ack_ok_d      = ack_ok_q;
    start_pos_d   = start_pos_q;
    start_spd_d   = start_spd_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;
    ram_we        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        case (item_q.kind)
          KIND_ENQUEUE: begin
            ack_ok_d = 1'b0;
            if (count_q < CntW'(QueueDepth)) begin
              ram_we   = 1'b1;
              wptr_d   = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
              count_d  = count_q + 1'b1;
              ack_ok_d = 1'b1;
            end
            pend_d[PB_ACK] = 1'b1;
          end
          KIND_TICK: begin
            if (ended) begin
              busy_d              = 1'b0;
              running_id_d        = IdNone;
              active_mask_d       = '0;
              ended_id_d          = running_id_q;
              ended_mask_d        = active_mask_q;
              pend_d[PB_TIMEOUT]  = !done;
              pend_d[PB_FINISH]   = (running_id_q != IdNone);
              pend_d[PB_EMPTY]    = (count_q == '0);
            end
            if ((!busy_q || ended) && count_q != '0) begin
              running_id_d     = head.id;
              active_mask_d    = head.mask & AllServos;
              start_pos_d      = head.positions;
              start_spd_d      = head.speeds;
              rptr_d           = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
              count_d          = count_q - 1'b1;
              busy_d           = 1'b1;
              start_time_d     = item_q.now_ms;
              pend_d[PB_START] = 1'b1;
            end
          end
          KIND_CLEAR, KIND_ESTOP, KIND_HOME: begin
            rptr_d           = '0;
            wptr_d           = '0;
            count_d          = '0;
            busy_d           = 1'b0;
            running_id_d     = IdNone;
            active_mask_d    = '0;
            pend_d[PB_FLUSH] = 1'b1;
            pend_d[PB_ESTOP] = (item_q.kind == KIND_ESTOP);
            pend_d[PB_HOME]  = (item_q.kind == KIND_HOME);
          end
          default: begin
          end
        endcase
        state_d = (pend_d != '0) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res;
          pend_d      = rest;
          if (rest == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pend_q        <= '0;
      rptr_q        <= '0;
      wptr_q        <= '0;
      count_q       <= '0;
      busy_q        <= 1'b0;
      running_id_q  <= IdNone;
      active_mask_q <= '0;
      start_time_q  <= '0;
      out_valid_q   <= 1'b0;
      timeout_q     <= TimeoutReset;
    end else begin
      state_q       <= state_d;
      pend_q        <= pend_d;
      rptr_q        <= rptr_d;
      wptr_q        <= wptr_d;
      count_q       <= count_d;
      busy_q        <= busy_d;
      running_id_q  <= running_id_d;
      active_mask_q <= active_mask_d;
      start_time_q  <= start_time_d;
      out_valid_q   <= out_valid_d;
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    ended_id_q   <= ended_id_d;
    ended_mask_q <= ended_mask_d;
    ack_ok_q     <= ack_ok_d;
    start_pos_q  <= start_pos_d;
    start_spd_q  <= start_spd_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The queue never holds more commands than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(QueueDepth))
    else $error("command queue count exceeds its depth");

  // An empty queue has its pointers together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (count_q == '0) |-> (wptr_q == rptr_q))
    else $error("empty command queue with pointers apart");

  // No servo is held active unless a command runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_q |-> (active_mask_q == '0))
    else $error("active servo mask set while no command runs");

  // The back end only takes a new item once every result of the last one is gone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_IDLE || state_q == ST_EVAL) |-> (pend_q == '0))
    else $error("results still pending outside the emit state");
`endif

endmodule

### design/motion_command_sequencer_unit.sv
// An accepted input beat passes through the front queue, the back end's item register and its
// evaluation step; its result beats then leave from the output register, one per cycle while the
// receiver is ready, up to three. The back end takes no new item until every result of the last
// one has been issued; a two-entry queue lets the front keep accepting meanwhile.
// Reset (rst_ni low, asynchronous): empty queue, no command running, timeout 2000 ms;
// the command store itself is not cleared, only entries that were written are read.
module motion_command_sequencer_unit import mcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  mcs_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output mcs_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic      item_valid;
  logic      item_ready;
  mcs_item_t item;

  // The timeout register takes a write beat at any time.
  assign cfg_ready_o = 1'b1;

  // Front end: accept and classify.
  mcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // Back end: queue, execution and results.
  mcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

### tb/motion_command_sequencer_unit_test.sv
// Self-checking testbench for the motion command sequencer: command queue, run, finish and flush.
`timescale 1ns / 100ps

module motion_command_sequencer_unit_test;
  import mcs_pkg::*;

  // Run control. The cycle limit is several times the slowest correct run: about 470 items,
  // each with up to three beats behind a sparse receiver, sender gaps and the block's own cycles.
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned ReportCap    = 100;

  // Opcodes the block ignores.
  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_SPARSE
  } ready_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  mcs_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  mcs_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;

  motion_command_sequencer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stimulus waiting to be sent and event beats still owed by the block.
  mcs_in_t  stimulus_items[$];
  mcs_out_t awaited_events[$];
  mcs_out_t step_events[$];

  // Shadow copy of the sequencer state.
  mcs_entry_t        cmd_store[QueueDepth];
  logic [PtrW-1:0]   head_ptr      = '0;
  logic [PtrW-1:0]   tail_ptr      = '0;
  logic [CntW-1:0]   waiting_count = '0;
  logic              cmd_running   = 1'b0;
  logic [31:0]       run_id        = IdNone;
  logic [5:0]        run_mask      = '0;
  logic [31:0]       run_start     = '0;
  logic [15:0]       timeout_limit = TimeoutReset;

  // Bookkeeping.
  int unsigned mismatches      = 0;
  int unsigned items_taken     = 0;
  int unsigned beats_checked   = 0;
  int unsigned starts_seen     = 0;
  int unsigned timeouts_seen   = 0;
  int unsigned refusals_seen   = 0;
  int unsigned settings_used   = 1;
  int unsigned gen_items       = 0;
  int unsigned gen_timeout     = TimeoutReset;
  logic [31:0] clock_ms        = '0;
  int unsigned cycle_count     = 0;
  int unsigned burst_left      = 0;
  int unsigned gap_left        = 0;
  int unsigned ready_tick      = 0;
  ready_mode_e ready_mode      = READY_ALWAYS;

  // Per-lane select: the low 'bits' bits of each lane whose servo bit is set.
  function automatic logic [47:0] lane_select(input logic [5:0] mask, input int unsigned bits);
    logic [47:0] sel;
    sel = '0;
    for (int i = 0; i < ServoCount; i++) begin
      if (mask[i]) begin
        sel[8*i +: 8] = 8'((9'(1) << bits) - 9'(1));
      end
    end
    return sel;
  endfunction

  // Appends one event beat, tagged with the queue state as it stands now.
  task automatic note_event(input mcs_event_e ev, input logic [31:0] id, input logic [5:0] mask,
                            input logic [47:0] pos, input logic [47:0] spd, input logic acc);
    mcs_out_t beat;
    beat.event_res       = ev;
    beat.event_id        = id;
    beat.servo_mask      = mask;
    beat.drive_positions = pos;
    beat.drive_speeds    = spd;
    beat.accepted        = acc;
    beat.queue_count     = 5'(waiting_count);
    beat.running         = cmd_running;
    beat.last            = 1'b0;
    step_events.push_back(beat);
  endtask

  // Computes the event beats one accepted input causes and queues them as awaited.
  task automatic sequencer_step(input mcs_in_t it);
    logic [5:0]  tmask;
    logic [31:0] elapsed;
    logic [31:0] ended_id;
    logic [5:0]  ended_mask;
    logic        done;
    logic        late;
    logic        ok;
    mcs_entry_t  slot;
    mcs_out_t    beat;
    step_events.delete();
    case (it.op)
      OP_ENQUEUE: begin
        ok = (waiting_count < QueueDepth);
        if (ok) begin
          tmask          = it.target_mask & AllServos;
          slot.id        = it.cmd_id;
          slot.mask      = tmask;
          slot.positions = it.target_positions & lane_select(tmask, PositionBits);
          slot.speeds    = it.target_speeds & lane_select(tmask, 8);
          cmd_store[tail_ptr] = slot;
          tail_ptr++;
          waiting_count++;
        end else begin
          refusals_seen++;
        end
        note_event(EV_ACK, IdNone, '0, '0, '0, ok);
      end
      OP_TICK: begin
        // Decide whether the running command ends on this tick.
        if (cmd_running) begin
          done    = (run_mask != '0) ? ((it.reached_mask & run_mask) == run_mask) : it.all_idle;
          elapsed = it.now_ms - run_start;
          late    = elapsed > 32'(timeout_limit);
          if (done || late) begin
            ended_id    = run_id;
            ended_mask  = run_mask;
            cmd_running = 1'b0;
            run_id      = IdNone;
            run_mask    = '0;
            if (!done) begin
              timeouts_seen++;
              note_event(EV_TIMEOUT, IdNone, ended_mask, '0, '0, 1'b0);
            end
            if (ended_id != IdNone) begin
              note_event(EV_FINISHED, ended_id, '0, '0, '0, 1'b0);
            end
            if (waiting_count == 0) begin
              note_event(EV_EMPTY, IdNone, '0, '0, '0, 1'b0);
            end
          end
        end
        // Start the next waiting command once the block is free.
        if (!cmd_running && waiting_count > 0) begin
          slot        = cmd_store[head_ptr];
          run_id      = slot.id;
          run_mask    = slot.mask & AllServos;
          head_ptr++;
          waiting_count--;
          cmd_running = 1'b1;
          run_start   = it.now_ms;
          starts_seen++;
          note_event(EV_STARTED, run_id, run_mask, slot.positions, slot.speeds, 1'b0);
        end
      end
      OP_CLEAR, OP_ESTOP, OP_GO_HOME: begin
        head_ptr      = '0;
        tail_ptr      = '0;
        waiting_count = '0;
        cmd_running   = 1'b0;
        run_id        = IdNone;
        run_mask      = '0;
        note_event(EV_EMPTY, IdNone, AllServos, '0, '0, 1'b0);
        if (it.op == OP_ESTOP) begin
          note_event(EV_ESTOP, IdNone, '0, '0, '0, 1'b0);
        end else if (it.op == OP_GO_HOME) begin
          note_event(EV_HOME, IdNone, '0, '0, '0, 1'b0);
        end
      end
      default: begin
      end
    endcase
    // The final beat of the input carries the last flag.
    if (step_events.size() > 0) begin
      beat      = step_events.pop_back();
      beat.last = 1'b1;
      step_events.push_back(beat);
    end
    while (step_events.size() > 0) begin
      awaited_events.push_back(step_events.pop_front());
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < ReportCap) begin
        $error("%s mismatch: expected %h, got %h", name, want, got);
      end
      mismatches++;
    end
  endtask

  // Compares one received beat with the oldest awaited one.
  task automatic check_beat(input mcs_out_t got);
    mcs_out_t want;
    if (awaited_events.size() == 0) begin
      if (mismatches < ReportCap) begin
        $error("unexpected beat: event %0d id %h", got.event_res, got.event_id);
      end
      mismatches++;
    end else begin
      want = awaited_events.pop_front();
      beats_checked++;
      check_field("event_res", want.event_res, got.event_res);
      check_field("event_id", want.event_id, got.event_id);
      check_field("servo_mask", want.servo_mask, got.servo_mask);
      check_field("drive_positions", want.drive_positions, got.drive_positions);
      check_field("drive_speeds", want.drive_speeds, got.drive_speeds);
      check_field("accepted", want.accepted, got.accepted);
      check_field("queue_count", want.queue_count, got.queue_count);
      check_field("running", want.running, got.running);
      check_field("last", want.last, got.last);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        items_taken++;
        sequencer_step(in_data_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 || stimulus_items.size() == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end
          in_valid_i <= 1'b0;
        end else begin
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
          end
          in_data_i  <= stimulus_items.pop_front();
          in_valid_i <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            gap_left = $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: checks each beat and stalls on a pattern that is redrawn at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_tick = 0;
      ready_mode = READY_ALWAYS;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_beat(out_data_o);
      end
      ready_tick++;
      if (ready_tick % 48 == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
      end
      case (ready_mode)
        READY_ALWAYS:   out_ready_i <= 1'b1;
        READY_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
        READY_PERIODIC: out_ready_i <= (ready_tick % 3 != 0);
        default:        out_ready_i <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("run stopped after %0d cycles with %0d beats still awaited",
               cycle_count, awaited_events.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [31:0] rand_id();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return IdNone;
    if (pick == 2) return 32'h7FFF_FFFF;
    if (pick == 3) return 32'h0;
    return $urandom & 32'h7FFF_FFFF;
  endfunction

  function automatic logic [5:0] rand_mask();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return 6'h00;
    if (pick == 2) return 6'h3F;
    return 6'($urandom);
  endfunction

  function automatic logic [5:0] rand_reached();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 6'h3F;
    if (pick < 8) return 6'($urandom);
    return 6'h00;
  endfunction

  task automatic push_item(input logic [2:0] op, input logic [31:0] id, input logic [5:0] tmask,
                           input logic [47:0] pos, input logic [47:0] spd,
                           input logic [5:0] reached, input logic idle, input logic [31:0] now);
    mcs_in_t it;
    it.op               = op;
    it.cmd_id           = id;
    it.target_mask      = tmask;
    it.target_positions = pos;
    it.target_speeds    = spd;
    it.reached_mask     = reached;
    it.all_idle         = idle;
    it.now_ms           = now;
    stimulus_items.push_back(it);
    if (op <= OP_GO_HOME) begin
      gen_items++;
    end
  endtask

  task automatic push_tick(input logic [5:0] reached, input logic idle, input logic [31:0] now);
    push_item(OP_TICK, rand_id(), 6'($urandom), rand48(), rand48(), reached, idle, now);
  endtask

  task automatic push_enqueue(input logic [31:0] id, input logic [5:0] mask,
                              input logic [47:0] pos, input logic [47:0] spd);
    push_item(OP_ENQUEUE, id, mask, pos, spd, 6'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic push_plain(input logic [2:0] op);
    push_item(op, rand_id(), 6'($urandom), rand48(), rand48(), 6'($urandom), 1'($urandom),
              $urandom);
  endtask

  // Moves the stimulus clock: mostly short steps, sometimes onto or past the limit.
  task automatic step_clock();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      clock_ms += $urandom_range(0, gen_timeout / 3);
    end else if (pick < 80) begin
      clock_ms += gen_timeout;
    end else if (pick < 92) begin
      clock_ms += gen_timeout + 1;
    end else begin
      clock_ms += $urandom;
    end
  endtask

  // Random traffic: mostly queued jobs followed by ticks, plus fills, flushes and noise.
  task automatic run_random(input int unsigned goal);
    int unsigned first;
    int unsigned pick;
    int unsigned jobs;
    first = gen_items;
    while (gen_items - first < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        jobs = $urandom_range(1, 4);
        repeat (jobs) push_enqueue(rand_id(), rand_mask(), rand48(), rand48());
        repeat ($urandom_range(jobs + 1, 3 * jobs + 3)) begin
          step_clock();
          push_tick(rand_reached(), 1'($urandom), clock_ms);
        end
      end else if (pick < 65) begin
        // Fill toward and past the queue's depth so some enqueues may be refused.
        repeat ($urandom_range(14, 20)) push_enqueue(rand_id(), rand_mask(), rand48(), rand48());
        repeat (2) begin
          step_clock();
          push_tick(rand_reached(), 1'($urandom), clock_ms);
        end
      end else if (pick < 75) begin
        push_plain(3'($urandom_range(OP_CLEAR, OP_GO_HOME)));
      end else if (pick < 85) begin
        push_plain(3'($urandom_range(OpUnusedLo, OpUnusedHi)));
      end else begin
        step_clock();
        push_item(3'($urandom_range(OP_TICK, OP_GO_HOME)), rand_id(), 6'($urandom), rand48(),
                  rand48(), 6'($urandom), 1'($urandom), clock_ms);
      end
    end
  endtask

  // Waits until every item is sent and every beat has come, then lets the block settle.
  task automatic drain();
    while (stimulus_items.size() != 0 || in_valid_i || awaited_events.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    drain();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    timeout_limit = value;
    gen_timeout   = value;
    settings_used++;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset timeout of 2000 ms.
    push_tick(6'h3F, 1'b1, 32'd100);
    push_plain(OpUnusedLo);
    push_plain(OpUnusedHi);
    push_enqueue(IdNone, 6'h3F, {48{1'b1}}, {48{1'b1}});
    push_enqueue(32'h7FFF_FFFF, 6'h00, rand48(), rand48());
    push_enqueue(32'h0, 6'h15, 48'hA5A5_5A5A_C3C3, 48'h0F0F_F0F0_1234);
    // Anonymous command starts, sees partial progress, then completes.
    push_tick(6'h00, 1'b0, 32'd1000);
    push_tick(6'h1F, 1'b1, 32'd1500);
    push_tick(6'h3F, 1'b0, 32'd1600);
    // A command without targets waits for all servos to be idle.
    push_tick(6'h3F, 1'b0, 32'd1700);
    push_tick(6'h00, 1'b1, 32'd1800);
    // Exactly at the limit the command still runs; one millisecond later it times out.
    push_tick(6'h2A, 1'b0, 32'd3800);
    push_tick(6'h2A, 1'b0, 32'd3801);
    // Elapsed time across the wrap of the millisecond clock.
    push_enqueue(32'd5, 6'h2A, rand48(), rand48());
    push_tick(6'h00, 1'b0, 32'hFFFF_FF00);
    push_tick(6'h00, 1'b0, 32'h0000_0100);
    push_tick(6'h00, 1'b0, 32'h0000_0800);
    // Flushes while a command runs and while one waits.
    push_enqueue(32'd9, 6'h03, rand48(), rand48());
    push_tick(6'h00, 1'b0, 32'd5000);
    push_plain(OP_CLEAR);
    push_enqueue(32'd11, 6'h01, rand48(), rand48());
    push_tick(6'h00, 1'b0, 32'd6000);
    push_plain(OP_ESTOP);
    push_enqueue(32'd12, 6'h02, rand48(), rand48());
    push_plain(OP_GO_HOME);
    clock_ms = 32'd7000;
    run_random(60);

    // Random phases over a range of timeout settings, the extremes first.
    write_timeout(16'd0);
    run_random(55);
    write_timeout(16'hFFFF);
    run_random(55);
    write_timeout(16'd1);
    run_random(55);
    write_timeout(16'd250);
    run_random(55);
    write_timeout(16'($urandom_range(2, 4000)));
    run_random(55);
    write_timeout(TimeoutReset);
    run_random(55);
    drain();

    if (awaited_events.size() != 0) begin
      $error("%0d beats never arrived", awaited_events.size());
      mismatches++;
    end
    $display("Sent %0d items over %0d timeout settings; %0d result beats compared.",
             items_taken, settings_used, beats_checked);
    $display("Commands: %0d started, %0d timed out, %0d enqueues refused on a full queue.",
             starts_seen, timeouts_seen, refusals_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
